### sv/lbc_pkg.sv
// Shared types and constants of the LRU block cache.
`timescale 1ns / 1ps
package lbc_pkg;

   localparam int unsigned ENTRIES   = 64;
   localparam int unsigned IDX_W     = 6;
   localparam int unsigned RANK_W    = 6;
   localparam int unsigned VCNT_W    = 7;
   localparam int unsigned ACT_W     = 7;
   localparam int unsigned USER_W    = 4;
   localparam int unsigned BLOCK_W   = 31;
   localparam int unsigned MAX_USERS = 16;
   localparam int unsigned NUSR_W    = 5;
   localparam int unsigned CNT_W     = 32;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_INVAL  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_HIT   = 2'd0,
      KIND_MISS  = 2'd1,
      KIND_STORE = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_ACTIVE_ENTRIES = 1'b0,
      CSR_NUM_USERS      = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PROBE  = 4'b0010,
      ST_SWORD  = 4'b0100,
      ST_STREAM = 4'b1000
   } state_type;

   // Search record that travels down the row of cells, one cell per cycle.
   typedef struct packed {
      logic               vld;
      logic [USER_W-1:0]  user;
      logic [BLOCK_W-1:0] block;
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic [RANK_W-1:0]  hit_rank;
      logic               free;
      logic [IDX_W-1:0]   free_idx;
      logic [RANK_W-1:0]  min_rank;
      logic [IDX_W-1:0]   min_idx;
      logic [VCNT_W-1:0]  vcnt;
   } probe_type;

   // Update broadcast to every cell in the same cycle.
   typedef struct packed {
      logic               clear_all;
      logic               gap_en;
      logic [RANK_W-1:0]  gap_rank;
      logic [IDX_W-1:0]   gap_skip;
      logic               wr_en;
      logic               wr_valid;
      logic [RANK_W-1:0]  wr_rank;
      logic               tag_en;
      logic [IDX_W-1:0]   idx;
      logic [USER_W-1:0]  user;
      logic [BLOCK_W-1:0] block;
   } upd_type;

endpackage

### sv/lbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbc_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lbc_cell.sv
// One cache entry: tag, valid bit and recency rank, plus one stage of the search chain.
`timescale 1ns / 1ps
module lbc_cell import lbc_pkg::*; #(
   parameter int unsigned CELL_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ACT_W-1:0]  active_entries,
   input  upd_type           upd,
   input  probe_type         probe_in,
   output probe_type         probe_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic               valid_ff, valid_in;
   logic [USER_W-1:0]  user_ff, user_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   probe_type          probe_ff, probe_in_nx;
   logic               act;
   logic               match;

   assign act   = ACT_W'(CELL_IDX) < active_entries;
   assign match = valid_ff && (user_ff == probe_in.user) && (block_ff == probe_in.block);

   always_comb begin
      valid_in = valid_ff;
      user_in  = user_ff;
      block_in = block_ff;
      rank_in  = rank_ff;
      if (upd.clear_all) begin
         valid_in = 1'b0;
         user_in  = '0;
         block_in = '0;
         rank_in  = '0;
      end else begin
         if (upd.gap_en && (upd.gap_skip != MY_IDX) && valid_ff && act &&
             (rank_ff > upd.gap_rank)) begin
            rank_in = rank_ff - 1'b1;
         end
         if (upd.wr_en && (upd.idx == MY_IDX)) begin
            valid_in = upd.wr_valid;
            rank_in  = upd.wr_rank;
         end
         if (upd.tag_en && (upd.idx == MY_IDX)) begin
            user_in  = upd.user;
            block_in = upd.block;
         end
      end
   end

   // The record picks up this entry's contribution as it passes.
   always_comb begin
      probe_in_nx = probe_in;
      if (probe_in.vld && act) begin
         if (valid_ff) begin
            probe_in_nx.vcnt = probe_in.vcnt + 1'b1;
         end
         if (match && !probe_in.hit) begin
            probe_in_nx.hit      = 1'b1;
            probe_in_nx.hit_idx  = MY_IDX;
            probe_in_nx.hit_rank = rank_ff;
         end
         if (!valid_ff && !probe_in.free) begin
            probe_in_nx.free     = 1'b1;
            probe_in_nx.free_idx = MY_IDX;
         end
         if (rank_ff < probe_in.min_rank) begin
            probe_in_nx.min_rank = rank_ff;
            probe_in_nx.min_idx  = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         user_ff      <= '0;
         block_ff     <= '0;
         rank_ff      <= '0;
         probe_ff.vld <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         user_ff      <= user_in;
         block_ff     <= block_in;
         rank_ff      <= rank_in;
         probe_ff.vld <= probe_in_nx.vld;
      end
      probe_ff.user     <= probe_in_nx.user;
      probe_ff.block    <= probe_in_nx.block;
      probe_ff.hit      <= probe_in_nx.hit;
      probe_ff.hit_idx  <= probe_in_nx.hit_idx;
      probe_ff.hit_rank <= probe_in_nx.hit_rank;
      probe_ff.free     <= probe_in_nx.free;
      probe_ff.free_idx <= probe_in_nx.free_idx;
      probe_ff.min_rank <= probe_in_nx.min_rank;
      probe_ff.min_idx  <= probe_in_nx.min_idx;
      probe_ff.vcnt     <= probe_in_nx.vcnt;
   end

   assign probe_out = probe_ff;

endmodule

### sv/lru_block_cache.sv
// Top level of the fully associative LRU block cache.
`timescale 1ns / 1ps
// Usage: an item is taken on a rising edge with start high and busy low. The
// item carries a command (lookup, store word, invalidate all, clear counters),
// the block tag and one data word. Results appear on the rsp_ ports for one
// cycle each, marked by rsp_valid; the receiver cannot hold them off.
// The entries form a row of 64 cells. A lookup, and the first word of a store
// run, send a search record down the row one cell per cycle. A miss result is
// on the ports in the cycle after the record leaves the last cell, and the
// block is idle again while it is shown. A hit streams BLOCK_WORDS data words,
// one per cycle, out of the block RAM through its read register; the block is
// idle again once the last read is issued. The first word of a store run is
// written in the state after its search; every later word of the run is
// written as it is taken. Invalidate and clear commands are done as they are
// taken, and their single result follows in the next cycle.
// Configuration registers are written through the csr_ channel, which is
// always ready; write it only while the block is idle. Writing the number
// of active entries also invalidates every entry.
// Synchronous reset empties the cache, zeroes all counters and returns the
// registers to 64 entries and 16 users; the block RAM is not cleared.
module lru_block_cache import lbc_pkg::*; #(
   parameter int unsigned BLOCK_WORDS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [USER_W-1:0]   req_user_id,
   input  logic [BLOCK_W-1:0]  req_block_id,
   input  logic [63:0]         req_data_word,
   input  logic                req_word_last,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic [63:0]         rsp_data_word_res,
   output logic [5:0]          rsp_slot,
   output logic                rsp_evicted,
   output logic [CNT_W-1:0]    rsp_count,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [ACT_W-1:0]    csr_wdata
);

   localparam int unsigned WW     = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int unsigned AW     = IDX_W + WW;
   localparam int unsigned DEPTH  = ENTRIES * (2 ** WW);
   localparam logic [WW-1:0] LAST_WORD = WW'(BLOCK_WORDS - 1);

   state_type          state_ff, state_in;
   logic [ACT_W-1:0]   active_ff, active_in;
   logic [NUSR_W-1:0]  nusers_ff, nusers_in;
   logic [CNT_W-1:0]   lookup_cnt_ff, lookup_cnt_in;
   logic [CNT_W-1:0]   store_cnt_ff [MAX_USERS];
   logic [CNT_W-1:0]   store_cnt_in [MAX_USERS];
   logic               fill_active_ff, fill_active_in;
   logic [IDX_W-1:0]   fill_slot_ff, fill_slot_in;
   logic [WW-1:0]      fill_word_ff, fill_word_in;
   logic               fill_evicted_ff, fill_evicted_in;
   logic [VCNT_W-1:0]  fill_vcnt_ff, fill_vcnt_in;
   logic [USER_W-1:0]  fill_user_ff, fill_user_in;
   logic               op_store_ff, op_store_in;
   logic [63:0]        op_data_ff, op_data_in;
   logic               op_last_ff, op_last_in;
   logic [IDX_W-1:0]   stream_slot_ff, stream_slot_in;
   logic [WW-1:0]      stream_w_ff, stream_w_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_last_ff, rd_last_in;
   logic               rsp_vld_ff, rsp_vld_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   upd_type            upd;
   probe_type          probe_head;
   probe_type          chain [ENTRIES+1];
   probe_type          probe_last;
   logic               do_word;
   logic [63:0]        word_data;
   logic               word_last;
   logic               word_final;
   logic [CNT_W-1:0]   cur_store_cnt;
   logic               user_counted;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [63:0]        ram_q;
   logic [NUSR_W-1:0]  nusers_wr;

   // Row of entry cells; the search record enters at cell zero.
   assign chain[0] = probe_head;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lbc_cell #(.CELL_IDX(g)) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active_entries (active_ff),
         .upd            (upd),
         .probe_in       (chain[g]),
         .probe_out      (chain[g+1])
      );
   end

   assign probe_last = chain[ENTRIES];

   lbc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (word_data),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign nusers_wr = csr_wdata[NUSR_W-1:0];

   // A word of a store run comes straight from the ports when the run is
   // already open, or from the held item once the first search has ended.
   assign word_data     = (state_ff == ST_SWORD) ? op_data_ff : req_data_word;
   assign word_last     = (state_ff == ST_SWORD) ? op_last_ff : req_word_last;
   assign word_final    = word_last || (fill_word_ff == LAST_WORD);
   assign cur_store_cnt = store_cnt_ff[fill_user_ff];
   assign user_counted  = {1'b0, fill_user_ff} < nusers_ff;
   assign ram_waddr     = {fill_slot_ff, fill_word_ff};
   assign ram_raddr     = {stream_slot_ff, stream_w_ff};

   always_comb begin
      state_in        = state_ff;
      active_in       = active_ff;
      nusers_in       = nusers_ff;
      lookup_cnt_in   = lookup_cnt_ff;
      store_cnt_in    = store_cnt_ff;
      fill_active_in  = fill_active_ff;
      fill_slot_in    = fill_slot_ff;
      fill_word_in    = fill_word_ff;
      fill_evicted_in = fill_evicted_ff;
      fill_vcnt_in    = fill_vcnt_ff;
      fill_user_in    = fill_user_ff;
      op_store_in     = op_store_ff;
      op_data_in      = op_data_ff;
      op_last_in      = op_last_ff;
      stream_slot_in  = stream_slot_ff;
      stream_w_in     = stream_w_ff;
      rd_pend_in      = 1'b0;
      rd_last_in      = 1'b0;
      rsp_vld_in      = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_in       = 1'b0;
      rsp_cnt_in      = '0;
      upd             = '0;
      do_word         = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      probe_head          = '0;
      probe_head.user     = req_user_id;
      probe_head.block    = req_block_id;
      probe_head.min_rank = '1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_data_in = req_data_word;
               op_last_in = req_word_last;
               unique case (cmd_type'(req_cmd))
                  CMD_LOOKUP: begin
                     if (lookup_cnt_ff != '1) begin
                        lookup_cnt_in = lookup_cnt_ff + 1'b1;
                     end
                     probe_head.vld = 1'b1;
                     op_store_in    = 1'b0;
                     state_in       = ST_PROBE;
                  end
                  CMD_STORE: begin
                     if (fill_active_ff) begin
                        do_word = 1'b1;
                     end else begin
                        probe_head.vld = 1'b1;
                        op_store_in    = 1'b1;
                        fill_user_in   = req_user_id;
                        state_in       = ST_PROBE;
                     end
                  end
                  CMD_INVAL: begin
                     upd.clear_all   = 1'b1;
                     fill_active_in  = 1'b0;
                     fill_word_in    = '0;
                     fill_evicted_in = 1'b0;
                     rsp_vld_in      = 1'b1;
                     rsp_kind_in     = KIND_DONE;
                     rsp_slot_in     = '0;
                  end
                  CMD_CLEAR: begin
                     lookup_cnt_in = '0;
                     for (int u = 0; u < MAX_USERS; u++) begin
                        store_cnt_in[u] = '0;
                     end
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = KIND_DONE;
                     rsp_slot_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (probe_last.vld) begin
               if (op_store_ff) begin
                  // Pick the first free entry, else the least recent one.
                  fill_active_in = 1'b1;
                  fill_word_in   = '0;
                  upd.tag_en     = 1'b1;
                  upd.user       = probe_last.user;
                  upd.block      = probe_last.block;
                  if (probe_last.free) begin
                     fill_slot_in    = probe_last.free_idx;
                     fill_evicted_in = 1'b0;
                     fill_vcnt_in    = probe_last.vcnt;
                     upd.idx         = probe_last.free_idx;
                  end else begin
                     fill_slot_in    = probe_last.min_idx;
                     fill_evicted_in = 1'b1;
                     fill_vcnt_in    = probe_last.vcnt - 1'b1;
                     upd.idx         = probe_last.min_idx;
                     upd.gap_en      = 1'b1;
                     upd.gap_rank    = probe_last.min_rank;
                     upd.gap_skip    = probe_last.min_idx;
                     upd.wr_en       = 1'b1;
                     upd.wr_valid    = 1'b0;
                     upd.wr_rank     = '0;
                  end
                  state_in = ST_SWORD;
               end else if (probe_last.hit) begin
                  // Touch: close the gap above the hit and make it most recent.
                  upd.gap_en     = 1'b1;
                  upd.gap_rank   = probe_last.hit_rank;
                  upd.gap_skip   = probe_last.hit_idx;
                  upd.wr_en      = 1'b1;
                  upd.wr_valid   = 1'b1;
                  upd.wr_rank    = RANK_W'(probe_last.vcnt - 1'b1);
                  upd.idx        = probe_last.hit_idx;
                  stream_slot_in = probe_last.hit_idx;
                  stream_w_in    = '0;
                  state_in       = ST_STREAM;
               end else begin
                  rsp_vld_in  = 1'b1;
                  rsp_kind_in = KIND_MISS;
                  rsp_slot_in = '0;
                  rsp_cnt_in  = lookup_cnt_ff;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_SWORD: begin
            do_word  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_STREAM: begin
            ram_re      = 1'b1;
            rd_pend_in  = 1'b1;
            rd_last_in  = (stream_w_ff == LAST_WORD);
            stream_w_in = stream_w_ff + 1'b1;
            if (stream_w_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_word) begin
         ram_we = 1'b1;
         if (word_final) begin
            upd.wr_en      = 1'b1;
            upd.wr_valid   = 1'b1;
            upd.wr_rank    = fill_vcnt_ff[RANK_W-1:0];
            upd.idx        = fill_slot_ff;
            rsp_vld_in     = 1'b1;
            rsp_kind_in    = KIND_STORE;
            rsp_slot_in    = fill_slot_ff;
            rsp_ev_in      = fill_evicted_ff;
            if (user_counted) begin
               if (cur_store_cnt != '1) begin
                  store_cnt_in[fill_user_ff] = cur_store_cnt + 1'b1;
                  rsp_cnt_in                 = cur_store_cnt + 1'b1;
               end else begin
                  rsp_cnt_in = cur_store_cnt;
               end
            end
            fill_active_in  = 1'b0;
            fill_word_in    = '0;
            fill_evicted_in = 1'b0;
         end else begin
            fill_word_in = fill_word_ff + 1'b1;
         end
      end

      // Register writes; a new entry count empties the cache.
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_ENTRIES: begin
               if (csr_wdata == '0) begin
                  active_in = ACT_W'(1);
               end else if (csr_wdata > ACT_W'(ENTRIES)) begin
                  active_in = ACT_W'(ENTRIES);
               end else begin
                  active_in = csr_wdata;
               end
               upd.clear_all   = 1'b1;
               fill_active_in  = 1'b0;
               fill_word_in    = '0;
               fill_evicted_in = 1'b0;
            end
            CSR_NUM_USERS: begin
               if (nusers_wr == '0) begin
                  nusers_in = NUSR_W'(1);
               end else if (nusers_wr > NUSR_W'(MAX_USERS)) begin
                  nusers_in = NUSR_W'(MAX_USERS);
               end else begin
                  nusers_in = nusers_wr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= ACT_W'(ENTRIES);
         nusers_ff       <= NUSR_W'(MAX_USERS);
         lookup_cnt_ff   <= '0;
         for (int u = 0; u < MAX_USERS; u++) begin
            store_cnt_ff[u] <= '0;
         end
         fill_active_ff  <= 1'b0;
         fill_slot_ff    <= '0;
         fill_word_ff    <= '0;
         fill_evicted_ff <= 1'b0;
         rd_pend_ff      <= 1'b0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         nusers_ff       <= nusers_in;
         lookup_cnt_ff   <= lookup_cnt_in;
         store_cnt_ff    <= store_cnt_in;
         fill_active_ff  <= fill_active_in;
         fill_slot_ff    <= fill_slot_in;
         fill_word_ff    <= fill_word_in;
         fill_evicted_ff <= fill_evicted_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_vld_ff      <= rsp_vld_in;
      end
      fill_vcnt_ff   <= fill_vcnt_in;
      fill_user_ff   <= fill_user_in;
      op_store_ff    <= op_store_in;
      op_data_ff     <= op_data_in;
      op_last_ff     <= op_last_in;
      stream_slot_ff <= stream_slot_in;
      stream_w_ff    <= stream_w_in;
      rd_last_ff     <= rd_last_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   // Hit words come from the RAM read register; every other result from the
   // result registers. The two never coincide.
   assign rsp_valid         = rd_pend_ff | rsp_vld_ff;
   assign rsp_kind          = rd_pend_ff ? KIND_HIT : rsp_kind_ff;
   assign rsp_data_word_res = rd_pend_ff ? ram_q : 64'd0;
   assign rsp_slot          = rd_pend_ff ? 6'(stream_slot_ff) : 6'(rsp_slot_ff);
   assign rsp_evicted       = rd_pend_ff ? 1'b0 : rsp_ev_ff;
   assign rsp_count         = rd_pend_ff ? lookup_cnt_ff : rsp_cnt_ff;
   assign rsp_last          = rd_pend_ff ? rd_last_ff : 1'b1;

   assert property (@(posedge clock) disable iff (reset) !(rd_pend_ff && rsp_vld_ff))
      else $error("hit word and single result collide");

   assert property (@(posedge clock) disable iff (reset)
      probe_last.vld |-> (state_ff == ST_PROBE))
      else $error("search record leaves the row outside a search");

   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(state_ff) == ST_STREAM))
      else $error("hit word without a RAM read");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_LOOKUP)) |=> busy)
      else $error("lookup taken without starting a search");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWORD) |-> fill_active_ff)
      else $error("first store word without an open run");

endmodule
